// ===== rtl/qinb_pkg.sv =====
// Shared types and constants of the QUBO implication network builder.
// Used by qinb_edge_out and qubo_implication_network_builder_core; no dependencies.
package qinb_pkg;

  // Largest supported variable count and the accumulator memory built from it.
  localparam int MAX_VARS = 64;
  localparam int ADDR_W   = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

  // Field widths fixed by the interface.
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 16;
  localparam int NVAR_W = 7;
  localparam int NODE_W = 8;
  localparam int CAP_W  = 22;
  localparam int ACC_W  = 22;
  localparam int SUM_W  = ACC_W + 1;
  localparam int OFS_W  = 40;
  localparam int INIT_W = 32;
  localparam int ONOW_W = 42;
  localparam int CFG_W  = 32;

  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 2 * NODE_W + CAP_W + ONOW_W;

  // Configuration register indexes.
  typedef enum logic {
    CFG_NUM_VARS = 1'b0,
    CFG_INIT_OFS = 1'b1
  } cfg_index_t;

  // Input item kinds carried on tuser.
  typedef enum logic {
    CMD_QUAD = 1'b0,
    CMD_LIN  = 1'b1
  } cmd_t;

  // One item's edge pair, handed from the accumulator stage to the output stage.
  typedef struct packed {
    logic [NODE_W-1:0]       from0;
    logic [NODE_W-1:0]       to0;
    logic [NODE_W-1:0]       from1;
    logic [NODE_W-1:0]       to1;
    logic [CAP_W-1:0]        cap;
    logic signed [SUM_W-1:0] sum;
    logic                    ofs_upd;
  } edge_pair_t;

endpackage

// ===== rtl/qubo_implication_network_builder_core.sv =====
// Top level of the QUBO implication network builder: configuration, accumulator memory
// and edge selection. Depends on qinb_pkg and qinb_edge_out.

// Each accepted coefficient item yields either nothing (lower triangle, diagonal or an
// index at or beyond the variable count) or a pair of edge writes on the master side,
// the second marked by tlast. The single output channel sets the sustained rate, but an
// item that yields nothing does not wait for it. The first edge of an item passes the
// stage 1, stage 2 and edge pair registers before it is presented and can be held there
// by back-pressure. The per-row linear accumulators sit in a 64-entry memory with a
// registered read and a bypass for a write to the same row in the cycle of the read;
// per-entry valid bits make rows read as zero after reset, so no clearing pass is
// needed. Configuration registers (num_variables, initial_offset) must be written
// by the user only while the block is idle; the block does not enforce this.
module qubo_implication_network_builder_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // s_tdata fields from bit 0 up: row, col, value, zero fill.
  input  logic [qinb_pkg::S_DATA_W-1:0]      s_tdata,
  // s_tuser fields from bit 0 up: cmd.
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // m_tdata fields from bit 0 up: from_node, to_node, capacity, offset_now.
  output logic [qinb_pkg::M_DATA_W-1:0]      m_tdata,
  // m_tlast: last.
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [qinb_pkg::CFG_W-1:0]         cfg_data
);

  logic [qinb_pkg::NVAR_W-1:0]        num_variables;
  logic signed [qinb_pkg::INIT_W-1:0] initial_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_variables  <= qinb_pkg::NVAR_W'(qinb_pkg::MAX_VARS);
      initial_offset <= '0;
    end else if (cfg_we) begin
      case (qinb_pkg::cfg_index_t'(cfg_index))
        qinb_pkg::CFG_NUM_VARS: num_variables  <= cfg_data[qinb_pkg::NVAR_W-1:0];
        qinb_pkg::CFG_INIT_OFS: initial_offset <= cfg_data[qinb_pkg::INIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [qinb_pkg::IDX_W-1:0]        in_row;
  logic [qinb_pkg::IDX_W-1:0]        in_col;
  logic signed [qinb_pkg::VAL_W-1:0] in_value;
  logic [qinb_pkg::ADDR_W-1:0]       in_addr;
  logic                              in_acc;

  assign in_row   = s_tdata[qinb_pkg::IDX_W-1:0];
  assign in_col   = s_tdata[2*qinb_pkg::IDX_W-1:qinb_pkg::IDX_W];
  assign in_value = s_tdata[2*qinb_pkg::IDX_W+qinb_pkg::VAL_W-1:2*qinb_pkg::IDX_W];
  assign in_addr  = qinb_pkg::ADDR_W'(in_row);
  assign in_acc   = s_tvalid && s_tready;

  // Accumulator memory with valid bits.
  logic [qinb_pkg::ACC_W-1:0] acc_mem [qinb_pkg::MAX_VARS];
  logic [qinb_pkg::MAX_VARS-1:0] acc_vld;
  logic                          wr_en;
  logic [qinb_pkg::ADDR_W-1:0]   wr_addr;
  logic [qinb_pkg::ACC_W-1:0]    wr_data;

  // Stage 1: item with its accumulator read.
  logic                              s1_valid;
  logic                              s1_cmd;
  logic [qinb_pkg::IDX_W-1:0]        s1_row;
  logic [qinb_pkg::IDX_W-1:0]        s1_col;
  logic signed [qinb_pkg::VAL_W-1:0] s1_value;
  logic [qinb_pkg::ACC_W-1:0]        rd_raw;
  logic                              rd_vld;
  logic                              rd_fwd;
  logic [qinb_pkg::ACC_W-1:0]        fwd_data;

  logic                 s1_adv;
  logic                 s1_keep;
  logic                 out_ready;
  qinb_pkg::edge_pair_t pair;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_mem[wr_addr] <= wr_data;
    end
    if (in_acc) begin
      rd_raw   <= acc_mem[in_addr];
      rd_fwd   <= wr_en && (wr_addr == in_addr);
      fwd_data <= wr_data;
      s1_cmd   <= s_tuser;
      s1_row   <= in_row;
      s1_col   <= in_col;
      s1_value <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld  <= '0;
      rd_vld   <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        acc_vld[wr_addr] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld <= acc_vld[in_addr];
      end
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
    end
  end

  // Edge selection and accumulator update.
  logic [qinb_pkg::NVAR_W-1:0]       n_eff;
  logic signed [qinb_pkg::ACC_W-1:0] acc_old;
  logic signed [qinb_pkg::SUM_W-1:0] sum;
  logic signed [qinb_pkg::SUM_W-1:0] operand;
  logic [qinb_pkg::SUM_W-1:0]        mag;
  logic                              neg;
  logic [qinb_pkg::NODE_W-1:0]       node_i;
  logic [qinb_pkg::NODE_W-1:0]       node_j;
  logic [qinb_pkg::NODE_W-1:0]       node_ni;
  logic [qinb_pkg::NODE_W-1:0]       node_nj;
  logic [qinb_pkg::NODE_W-1:0]       node_src;
  logic [qinb_pkg::NODE_W-1:0]       node_sink;

  always_comb begin
    if (num_variables == '0) begin
      n_eff = qinb_pkg::NVAR_W'(1);
    end else if (int'(num_variables) > qinb_pkg::MAX_VARS) begin
      n_eff = qinb_pkg::NVAR_W'(qinb_pkg::MAX_VARS);
    end else begin
      n_eff = num_variables;
    end

    s1_keep = ({1'b0, s1_row} < n_eff) &&
              ((s1_cmd == qinb_pkg::CMD_LIN) ||
               (({1'b0, s1_col} < n_eff) && (s1_row < s1_col)));

    // A row never written since reset reads as zero.
    acc_old = rd_fwd ? fwd_data : (rd_vld ? rd_raw : '0);
    sum     = qinb_pkg::SUM_W'(acc_old) + qinb_pkg::SUM_W'(s1_value);

    operand = (s1_cmd == qinb_pkg::CMD_LIN) ? sum : qinb_pkg::SUM_W'(s1_value);
    neg     = operand[qinb_pkg::SUM_W-1];
    mag     = neg ? -operand : operand;

    node_i    = qinb_pkg::NODE_W'(s1_row);
    node_j    = qinb_pkg::NODE_W'(s1_col);
    node_ni   = qinb_pkg::NODE_W'(s1_row) + qinb_pkg::NODE_W'(n_eff) + qinb_pkg::NODE_W'(1);
    node_nj   = qinb_pkg::NODE_W'(s1_col) + qinb_pkg::NODE_W'(n_eff) + qinb_pkg::NODE_W'(1);
    node_src  = qinb_pkg::NODE_W'(n_eff);
    node_sink = qinb_pkg::NODE_W'(n_eff) + qinb_pkg::NODE_W'(n_eff) + qinb_pkg::NODE_W'(1);

    pair.cap     = mag[qinb_pkg::CAP_W-1:0];
    pair.sum     = sum;
    pair.ofs_upd = (s1_cmd == qinb_pkg::CMD_LIN) && neg;
    if (s1_cmd == qinb_pkg::CMD_LIN) begin
      pair.from0 = node_src;
      pair.to0   = neg ? node_i : node_ni;
      pair.from1 = neg ? node_ni : node_i;
      pair.to1   = node_sink;
    end else begin
      pair.from0 = node_i;
      pair.to0   = neg ? node_j : node_nj;
      pair.from1 = neg ? node_nj : node_j;
      pair.to1   = node_ni;
    end

    s1_adv = s1_valid && (!s1_keep || out_ready);

    // Negative quadratic coefficients fold into the row accumulator, saturated.
    wr_en   = s1_adv && s1_keep && (s1_cmd == qinb_pkg::CMD_QUAD) && s1_value[qinb_pkg::VAL_W-1];
    wr_addr = qinb_pkg::ADDR_W'(s1_row);
    if (sum[qinb_pkg::SUM_W-1] != sum[qinb_pkg::SUM_W-2]) begin
      wr_data = {sum[qinb_pkg::SUM_W-1], {(qinb_pkg::ACC_W-1){~sum[qinb_pkg::SUM_W-1]}}};
    end else begin
      wr_data = sum[qinb_pkg::ACC_W-1:0];
    end
  end

  assign s_tready = !s1_valid || s1_adv;

  qinb_edge_out u_edge_out (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s1_valid && s1_keep),
    .in_ready       (out_ready),
    .in_pair        (pair),
    .initial_offset (initial_offset),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast)
  );

endmodule

// ===== rtl/qinb_edge_out.sv =====
// Output side of the implication network builder: offset accumulator and edge pair register.
// Depends on qinb_pkg.
module qinb_edge_out (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  qinb_pkg::edge_pair_t                in_pair,
  input  logic signed [qinb_pkg::INIT_W-1:0]  initial_offset,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata fields from bit 0 up: from_node, to_node, capacity, offset_now.
  output logic [qinb_pkg::M_DATA_W-1:0]       m_tdata,
  output logic                                m_tlast
);

  // Stage holding the item while the offset is updated.
  logic                  s2_valid;
  qinb_pkg::edge_pair_t  s2_pair;
  logic                  s2_adv;

  logic signed [qinb_pkg::OFS_W-1:0]  ofs_acc;
  logic signed [qinb_pkg::OFS_W:0]    ofs_sum;
  logic signed [qinb_pkg::OFS_W-1:0]  ofs_next;

  // Edge pair register; phase selects the edge being shown.
  logic                               p_valid;
  logic                               p_phase;
  qinb_pkg::edge_pair_t               p_pair;
  logic signed [qinb_pkg::ONOW_W-1:0] p_ofs_now;
  logic                               p_done;

  assign p_done   = p_valid && p_phase && m_tready;
  assign s2_adv   = s2_valid && (!p_valid || p_done);
  assign in_ready = !s2_valid || s2_adv;

  always_comb begin
    ofs_sum = (qinb_pkg::OFS_W+1)'(ofs_acc) + (qinb_pkg::OFS_W+1)'(s2_pair.sum);
    ofs_next = ofs_acc;
    if (s2_pair.ofs_upd) begin
      // Saturate to the accumulator range when the sum leaves it.
      if (ofs_sum[qinb_pkg::OFS_W] != ofs_sum[qinb_pkg::OFS_W-1]) begin
        ofs_next = {ofs_sum[qinb_pkg::OFS_W], {(qinb_pkg::OFS_W-1){~ofs_sum[qinb_pkg::OFS_W]}}};
      end else begin
        ofs_next = ofs_sum[qinb_pkg::OFS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      p_valid  <= 1'b0;
      p_phase  <= 1'b0;
      ofs_acc  <= '0;
    end else begin
      if (in_ready) begin
        s2_valid <= in_valid;
      end
      if (s2_adv) begin
        ofs_acc <= ofs_next;
        p_valid <= 1'b1;
        p_phase <= 1'b0;
      end else if (p_done) begin
        p_valid <= 1'b0;
        p_phase <= 1'b0;
      end else if (p_valid && m_tready) begin
        p_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s2_pair <= in_pair;
    end
    if (s2_adv) begin
      p_pair    <= s2_pair;
      p_ofs_now <= qinb_pkg::ONOW_W'(initial_offset) + qinb_pkg::ONOW_W'(ofs_next);
    end
  end

  assign m_tvalid = p_valid;
  assign m_tlast  = p_phase;
  assign m_tdata  = p_phase ? {p_ofs_now, p_pair.cap, p_pair.to1, p_pair.from1}
                            : {p_ofs_now, p_pair.cap, p_pair.to0, p_pair.from0};

endmodule

// ===== test/qubo_implication_network_builder_core_tb.sv =====
// Self-checking testbench for qubo_implication_network_builder_core: directed coefficient
// items, then randomized row sequences under several register settings and flow patterns.
// Depends on qinb_pkg and the RTL of the builder.
`timescale 1ns / 100ps

module qubo_implication_network_builder_core_tb;

  localparam int     QUIET_LIMIT = 4000;
  localparam int     DRAIN_CYCLES = 20;
  localparam longint ACC_HI = (64'sd1 <<< (qinb_pkg::ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint OFS_HI = (64'sd1 <<< (qinb_pkg::OFS_W - 1)) - 1;
  localparam longint OFS_LO = -OFS_HI - 1;

  typedef struct packed {
    logic [qinb_pkg::NODE_W-1:0]        from_n;
    logic [qinb_pkg::NODE_W-1:0]        to_n;
    logic [qinb_pkg::CAP_W-1:0]         cap;
    logic signed [qinb_pkg::ONOW_W-1:0] ofs;
    logic                               last;
  } edge_t;

  localparam edge_t NO_EDGE = '0;

  typedef struct packed {
    qinb_pkg::cmd_t             cmd;
    logic [qinb_pkg::IDX_W-1:0] row;
    logic [qinb_pkg::IDX_W-1:0] col;
    logic [qinb_pkg::VAL_W-1:0] value;
    logic                       typed;
    logic [1:0]                 n_edges;
    edge_t                      e0;
    edge_t                      e1;
  } coef_row_t;

  typedef struct packed {
    logic [qinb_pkg::NVAR_W-1:0] nvars;
    logic [qinb_pkg::INIT_W-1:0] init;
    logic [7:0]                  idle_pct;
    logic [7:0]                  stall_pct;
    logic [10:0]                 items;
    logic                        saturate;
  } phase_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [qinb_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic                          s_tuser = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [qinb_pkg::M_DATA_W-1:0] m_tdata;
  logic                          m_tlast;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = 1'b0;
  logic [qinb_pkg::CFG_W-1:0]    cfg_data = '0;

  // Predictor state, kept in step with the block.
  logic [qinb_pkg::NVAR_W-1:0] num_vars = 7'd64;
  longint                      init_ofs = 0;
  longint                      row_sum [qinb_pkg::MAX_VARS];
  longint                      offset_sum = 0;
  edge_t                       pending_edges [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  edge_t got_edge, want_edge;

  coef_row_t directed_items [16];
  phase_t    phases [8];

  qubo_implication_network_builder_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Node fields keep their low bits, as the block's ports do.
  function automatic edge_t make_edge(input longint from_n, input longint to_n,
                                      input longint cap, input longint ofs,
                                      input logic last);
    edge_t e;
    e.from_n = qinb_pkg::NODE_W'(from_n);
    e.to_n   = qinb_pkg::NODE_W'(to_n);
    e.cap    = qinb_pkg::CAP_W'(cap);
    e.ofs    = qinb_pkg::ONOW_W'(ofs);
    e.last   = last;
    return e;
  endfunction

  // Computes the edge pair of one coefficient and updates the accumulators.
  function automatic int predict_edges(input qinb_pkg::cmd_t cmd,
                                       input logic [qinb_pkg::IDX_W-1:0] row,
                                       input logic [qinb_pkg::IDX_W-1:0] col,
                                       input logic signed [qinb_pkg::VAL_W-1:0] value,
                                       output edge_t e0, output edge_t e1);
    longint n, v, s, ofs, i, j;
    n = longint'(num_vars);
    if (n == 0) n = 1;
    if (n > qinb_pkg::MAX_VARS) n = qinb_pkg::MAX_VARS;
    v = longint'(value);
    i = longint'(row);
    j = longint'(col);
    e0 = NO_EDGE;
    e1 = NO_EDGE;
    if (i >= n) return 0;
    if (cmd == qinb_pkg::CMD_QUAD) begin
      if (j >= n || i >= j) return 0;
      if (v < 0) row_sum[row] = clamp(row_sum[row] + v, ACC_LO, ACC_HI);
      ofs = init_ofs + offset_sum;
      if (v >= 0) begin
        e0 = make_edge(i, j + n + 1, v, ofs, 1'b0);
        e1 = make_edge(j, i + n + 1, v, ofs, 1'b1);
      end else begin
        e0 = make_edge(i, j, -v, ofs, 1'b0);
        e1 = make_edge(j + n + 1, i + n + 1, -v, ofs, 1'b1);
      end
    end else begin
      s = v + row_sum[row];
      if (s < 0) offset_sum = clamp(offset_sum + s, OFS_LO, OFS_HI);
      ofs = init_ofs + offset_sum;
      if (s >= 0) begin
        e0 = make_edge(n, i + n + 1, s, ofs, 1'b0);
        e1 = make_edge(i, 2 * n + 1, s, ofs, 1'b1);
      end else begin
        e0 = make_edge(n, i, -s, ofs, 1'b0);
        e1 = make_edge(i + n + 1, 2 * n + 1, -s, ofs, 1'b1);
      end
    end
    return 2;
  endfunction

  function automatic logic [qinb_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return qinb_pkg::VAL_W'($urandom());
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is accepted.
  task automatic send_coef(input qinb_pkg::cmd_t cmd, input logic [qinb_pkg::IDX_W-1:0] row,
                           input logic [qinb_pkg::IDX_W-1:0] col,
                           input logic [qinb_pkg::VAL_W-1:0] value,
                           input logic typed, input logic [1:0] typed_count,
                           input edge_t t0, input edge_t t1, output int produced);
    edge_t e0, e1;
    int n_pred;
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(qinb_pkg::S_DATA_W - 2 * qinb_pkg::IDX_W - qinb_pkg::VAL_W){1'b0}},
                 value, col, row};
    do @(posedge clk); while (!s_tready);
    n_pred = predict_edges(cmd, row, col, value, e0, e1);
    if (typed) begin
      if (typed_count != 0) begin
        pending_edges.push_back(t0);
        pending_edges.push_back(t1);
      end
    end else if (n_pred != 0) begin
      pending_edges.push_back(e0);
      pending_edges.push_back(e1);
    end
    produced = n_pred;
    @(negedge clk);
  endtask

  task automatic cfg_write(input qinb_pkg::cfg_index_t idx,
                           input logic [qinb_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == qinb_pkg::CFG_NUM_VARS) num_vars = data[qinb_pkg::NVAR_W-1:0];
    else init_ofs = longint'($signed(data[qinb_pkg::INIT_W-1:0]));
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Lets the block drain before a register write; items with no edges may still be in flight.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin
    m_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_edge.from_n = m_tdata[qinb_pkg::NODE_W-1:0];
      got_edge.to_n   = m_tdata[2*qinb_pkg::NODE_W-1:qinb_pkg::NODE_W];
      got_edge.cap    = m_tdata[2*qinb_pkg::NODE_W+qinb_pkg::CAP_W-1:2*qinb_pkg::NODE_W];
      got_edge.ofs    = m_tdata[qinb_pkg::M_DATA_W-1:2*qinb_pkg::NODE_W+qinb_pkg::CAP_W];
      got_edge.last   = m_tlast;
      if (pending_edges.size() == 0) begin
        $display("%0t: unexpected edge, expected none, got from %0d to %0d cap %0d",
                 $time, got_edge.from_n, got_edge.to_n, got_edge.cap);
        fail_count++;
      end else begin
        want_edge = pending_edges.pop_front();
        check_field("from_node", longint'(want_edge.from_n), longint'(got_edge.from_n));
        check_field("to_node", longint'(want_edge.to_n), longint'(got_edge.to_n));
        check_field("capacity", longint'(want_edge.cap), longint'(got_edge.cap));
        check_field("offset_now", longint'(want_edge.ofs), longint'(got_edge.ofs));
        check_field("last", longint'(want_edge.last), longint'(got_edge.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int got, done, r, c, nq, neff, p, k;
    for (k = 0; k < qinb_pkg::MAX_VARS; k++) row_sum[k] = 0;

    // Rows with typed edges follow directly from reset values: N = 64, source 64, sink 129.
    directed_items[0]  = '{qinb_pkg::CMD_QUAD, 6'd0, 6'd63, 16'h7fff, 1'b1, 2'd2,
                           '{8'd0, 8'd128, 22'd32767, 42'sd0, 1'b0},
                           '{8'd63, 8'd65, 22'd32767, 42'sd0, 1'b1}};
    directed_items[1]  = '{qinb_pkg::CMD_QUAD, 6'd0, 6'd1, 16'h8000, 1'b1, 2'd2,
                           '{8'd0, 8'd1, 22'd32768, 42'sd0, 1'b0},
                           '{8'd66, 8'd65, 22'd32768, 42'sd0, 1'b1}};
    directed_items[2]  = '{qinb_pkg::CMD_QUAD, 6'd62, 6'd63, 16'h0000, 1'b1, 2'd2,
                           '{8'd62, 8'd128, 22'd0, 42'sd0, 1'b0},
                           '{8'd63, 8'd127, 22'd0, 42'sd0, 1'b1}};
    directed_items[3]  = '{qinb_pkg::CMD_QUAD, 6'd5, 6'd5, 16'd7, 1'b1, 2'd0,
                           NO_EDGE, NO_EDGE};
    directed_items[4]  = '{qinb_pkg::CMD_QUAD, 6'd10, 6'd3, 16'hffff, 1'b1, 2'd0,
                           NO_EDGE, NO_EDGE};
    directed_items[5]  = '{qinb_pkg::CMD_LIN, 6'd0, 6'd0, 16'd100, 1'b1, 2'd2,
                           '{8'd64, 8'd0, 22'd32668, -42'sd32668, 1'b0},
                           '{8'd65, 8'd129, 22'd32668, -42'sd32668, 1'b1}};
    directed_items[6]  = '{qinb_pkg::CMD_LIN, 6'd63, 6'd63, 16'h7fff, 1'b1, 2'd2,
                           '{8'd64, 8'd128, 22'd32767, -42'sd32668, 1'b0},
                           '{8'd63, 8'd129, 22'd32767, -42'sd32668, 1'b1}};
    directed_items[7]  = '{qinb_pkg::CMD_LIN, 6'd1, 6'd0, 16'h0000, 1'b1, 2'd2,
                           '{8'd64, 8'd66, 22'd0, -42'sd32668, 1'b0},
                           '{8'd1, 8'd129, 22'd0, -42'sd32668, 1'b1}};
    directed_items[8]  = '{qinb_pkg::CMD_LIN, 6'd2, 6'd0, 16'h8000, 1'b1, 2'd2,
                           '{8'd64, 8'd2, 22'd32768, -42'sd65436, 1'b0},
                           '{8'd67, 8'd129, 22'd32768, -42'sd65436, 1'b1}};
    // Back-to-back items on one row exercise the accumulator bypass.
    directed_items[9]  = '{qinb_pkg::CMD_QUAD, 6'd3, 6'd4, -16'sd5, 1'b0, 2'd0,
                           NO_EDGE, NO_EDGE};
    directed_items[10] = '{qinb_pkg::CMD_QUAD, 6'd3, 6'd9, -16'sd7, 1'b0, 2'd0,
                           NO_EDGE, NO_EDGE};
    directed_items[11] = '{qinb_pkg::CMD_LIN, 6'd3, 6'd0, 16'd0, 1'b0, 2'd0,
                           NO_EDGE, NO_EDGE};
    directed_items[12] = '{qinb_pkg::CMD_QUAD, 6'd61, 6'd62, -16'sd300, 1'b0, 2'd0,
                           NO_EDGE, NO_EDGE};
    directed_items[13] = '{qinb_pkg::CMD_LIN, 6'd61, 6'd40, 16'h7fff, 1'b0, 2'd0,
                           NO_EDGE, NO_EDGE};
    directed_items[14] = '{qinb_pkg::CMD_QUAD, 6'd1, 6'd63, -16'sd1, 1'b0, 2'd0,
                           NO_EDGE, NO_EDGE};
    directed_items[15] = '{qinb_pkg::CMD_LIN, 6'd1, 6'd63, 16'h8000, 1'b0, 2'd0,
                           NO_EDGE, NO_EDGE};

    phases[0] = '{7'd64, 32'h7fffffff, 8'd0, 8'd0, 11'd200, 1'b1};
    phases[1] = '{7'd1, 32'h80000000, 8'd70, 8'd0, 11'd100, 1'b0};
    phases[2] = '{7'd0, $urandom(), 8'd0, 8'd70, 11'd100, 1'b0};
    phases[3] = '{7'd127, $urandom(), 8'd18, 8'd18, 11'd250, 1'b0};
    phases[4] = '{7'd2, 32'h00000000, 8'd70, 8'd0, 11'd100, 1'b0};
    phases[5] = '{7'd37, $urandom(), 8'd18, 8'd18, 11'd200, 1'b0};
    phases[6] = '{7'd64, 32'hffffffff, 8'd0, 8'd70, 11'd200, 1'b1};
    phases[7] = '{7'd100, $urandom(), 8'd0, 8'd0, 11'd200, 1'b0};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (k = 0; k < 16; k++) begin
      send_coef(directed_items[k].cmd, directed_items[k].row, directed_items[k].col,
                directed_items[k].value, directed_items[k].typed,
                directed_items[k].n_edges, directed_items[k].e0, directed_items[k].e1, got);
    end

    for (p = 0; p < 8; p++) begin
      settle();
      cfg_write(qinb_pkg::CFG_NUM_VARS,
                {{(qinb_pkg::CFG_W - qinb_pkg::NVAR_W){1'b0}}, phases[p].nvars});
      cfg_write(qinb_pkg::CFG_INIT_OFS, phases[p].init);
      idle_pct  = int'(phases[p].idle_pct);
      stall_pct = int'(phases[p].stall_pct);
      neff = int'(num_vars);
      if (neff == 0) neff = 1;
      if (neff > qinb_pkg::MAX_VARS) neff = qinb_pkg::MAX_VARS;
      done = 0;

      // Drive one row's accumulator well past its negative limit, then read it back.
      if (phases[p].saturate) begin
        r = $urandom_range(0, neff / 2 - 1);
        repeat (70) begin
          send_coef(qinb_pkg::CMD_QUAD, qinb_pkg::IDX_W'(r),
                    qinb_pkg::IDX_W'($urandom_range(r + 1, neff - 1)), 16'h8000, 1'b0, 2'd0,
                    NO_EDGE, NO_EDGE, got);
          done += int'(got != 0);
        end
        send_coef(qinb_pkg::CMD_LIN, qinb_pkg::IDX_W'(r), qinb_pkg::IDX_W'($urandom()),
                  pick_value(), 1'b0, 2'd0, NO_EDGE, NO_EDGE, got);
        done += int'(got != 0);
      end

      while (done < int'(phases[p].items)) begin
        if ($urandom_range(0, 99) < 20) begin
          send_coef(qinb_pkg::cmd_t'($urandom_range(0, 1)), qinb_pkg::IDX_W'($urandom()),
                    qinb_pkg::IDX_W'($urandom()), qinb_pkg::VAL_W'($urandom()),
                    1'b0, 2'd0, NO_EDGE, NO_EDGE, got);
          done += int'(got != 0);
        end else begin
          // A row's quadratic items, then its linear item.
          r  = $urandom_range(0, neff - 1);
          nq = $urandom_range(0, 4);
          repeat (nq) begin
            if (r < neff - 1) begin
              c = $urandom_range(r + 1, neff - 1);
              send_coef(qinb_pkg::CMD_QUAD, qinb_pkg::IDX_W'(r), qinb_pkg::IDX_W'(c),
                        pick_value(), 1'b0, 2'd0, NO_EDGE, NO_EDGE, got);
              done += int'(got != 0);
            end
          end
          send_coef(qinb_pkg::CMD_LIN, qinb_pkg::IDX_W'(r), qinb_pkg::IDX_W'($urandom()),
                    pick_value(), 1'b0, 2'd0, NO_EDGE, NO_EDGE, got);
          done += int'(got != 0);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
